/* hdl/line_tracking_pid_steer_defines.svh */
// assertion macros for the line tracking steering block
`ifndef LINE_TRACKING_PID_STEER_DEFINES_SVH
`define LINE_TRACKING_PID_STEER_DEFINES_SVH

// property checked outside reset
`define LTS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("steering datapath check failed");

// property checked at every edge, reset included
`define LTS_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("steering reset check failed");

`endif

/* hdl/lts_pkg.sv */
// shared types, widths and register codes for the line tracking steering block
`default_nettype none

package lts_pkg;

  localparam int SENSOR_COUNT_DEF = 7;
  localparam int SENSOR_COUNT_MAX = 16;
  localparam int IDX_W            = $clog2(SENSOR_COUNT_MAX);
  localparam int QUEUE_DEPTH_DEF  = 2;

  localparam int GAIN_W     = 8;
  localparam int CENTER_W   = 3;
  localparam int ERR_W      = 4;
  localparam int DIFF_W     = ERR_W + 1;
  localparam int SUM_W      = 16;
  localparam int STEER_W    = 9;
  localparam int DRIVE_W    = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [GAIN_W-1:0]   GAIN_P_RST      = 8'd60;
  localparam logic [GAIN_W-1:0]   GAIN_I_RST      = 8'd10;
  localparam logic [GAIN_W-1:0]   GAIN_D_RST      = 8'd0;
  localparam logic [GAIN_W-1:0]   BASE_SPEED_RST  = 8'd128;
  localparam logic [GAIN_W-1:0]   STEER_LIMIT_RST = 8'd125;
  localparam logic [CENTER_W-1:0] CENTER_RST      = 3'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P      = 3'd0,
    REG_GAIN_I      = 3'd1,
    REG_GAIN_D      = 3'd2,
    REG_BASE_SPEED  = 3'd3,
    REG_STEER_LIMIT = 3'd4,
    REG_CENTER      = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [GAIN_W-1:0]   gain_p;
    logic [GAIN_W-1:0]   gain_i;
    logic [GAIN_W-1:0]   gain_d;
    logic [GAIN_W-1:0]   base_speed;
    logic [GAIN_W-1:0]   steer_limit;
    logic [CENTER_W-1:0] center_index;
  } cfg_t;

  // classified sample handed from front to back
  typedef struct packed {
    logic             seen;
    logic [IDX_W-1:0] idx;
  } class_t;

endpackage

`default_nettype wire

/* hdl/lts_if.sv */
// stream interfaces for sensor samples and drive results
`default_nettype none

interface lts_sense_if
  import lts_pkg::*;
#(
  parameter int SENSOR_COUNT = SENSOR_COUNT_DEF
) ();
  logic                    valid;
  logic                    ready;
  logic [SENSOR_COUNT-1:0] sensor_bits;

  modport source (output valid, output sensor_bits, input ready);
  modport sink   (input valid, input sensor_bits, output ready);
endinterface

interface lts_drive_if
  import lts_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] left_drive;
  logic signed [DRIVE_W-1:0] right_drive;
  logic signed [STEER_W-1:0] steer_signal;
  logic                      line_seen;

  modport source (output valid, output left_drive, output right_drive,
                  output steer_signal, output line_seen, input ready);
  modport sink   (input valid, input left_drive, input right_drive,
                  input steer_signal, input line_seen, output ready);
endinterface

`default_nettype wire

/* hdl/line_tracking_pid_steer.sv */
// top level of the line tracking steering controller
`default_nettype none

// Steering controller for a line-following robot. Each beat on the sense
// channel is one control tick carrying one bit per line sensor; each beat on
// the drive channel is the matching result (left and right wheel drive, the
// clamped steering signal, and whether any sensor saw the line). Throughput is
// one sample per clock until a stall on the drive side fills the fifo. The
// front end priority-encodes the highest lit sensor as the sample is taken
// and drops it into a small fifo; from the head of that fifo the back end
// runs it through its stages (error and running sum update, the three gain
// multiplies, then sum, clamp and wheel mix into the output register) before
// it shows up on the drive channel. The fifo lets the front keep taking samples
// while a result is held up on the drive side; the sense channel only drops
// ready once the fifo is full. Registers are written through the plain write
// port and should only be changed while no sample is in flight. With no
// sensor lit the previous error is reused and line_seen is low; the error sum
// saturates at sixteen bits signed.

`include "line_tracking_pid_steer_defines.svh"

module line_tracking_pid_steer
  import lts_pkg::*;
#(
  parameter int SENSOR_COUNT = SENSOR_COUNT_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  lts_sense_if.sink                  sense,
  lts_drive_if.source                drive,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t   cfg;
  logic   push;
  class_t push_entry;
  logic   queue_full;
  logic   pop;
  class_t pop_entry;
  logic   queue_valid;

  // configuration registers, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p       <= GAIN_P_RST;
      cfg.gain_i       <= GAIN_I_RST;
      cfg.gain_d       <= GAIN_D_RST;
      cfg.base_speed   <= BASE_SPEED_RST;
      cfg.steer_limit  <= STEER_LIMIT_RST;
      cfg.center_index <= CENTER_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_GAIN_P:      cfg.gain_p       <= cfg_data;
        REG_GAIN_I:      cfg.gain_i       <= cfg_data;
        REG_GAIN_D:      cfg.gain_d       <= cfg_data;
        REG_BASE_SPEED:  cfg.base_speed   <= cfg_data;
        REG_STEER_LIMIT: cfg.steer_limit  <= cfg_data;
        REG_CENTER:      cfg.center_index <= cfg_data[CENTER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // front end: accept and classify
  lts_front #(
    .SENSOR_COUNT (SENSOR_COUNT)
  ) u_front (
    .sense      (sense),
    .queue_full (queue_full),
    .push       (push),
    .entry      (push_entry)
  );

  // decoupling fifo
  lts_queue #(
    .WIDTH ($bits(class_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_entry),
    .full      (queue_full),
    .pop       (pop),
    .pop_data  (pop_entry),
    .not_empty (queue_valid)
  );

  // back end: pid datapath and output register
  lts_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (queue_valid),
    .q_entry (pop_entry),
    .q_pop   (pop),
    .drive   (drive)
  );

  // wheels always differ by twice the steering signal
  `LTS_ASSERT(a_wheel_split, clk, rst,
    drive.valid |-> ((drive.left_drive - drive.right_drive) == ({drive.steer_signal, 1'b0})))
  // pipeline empties on reset
  `LTS_ASSERT_RST(a_reset_empty, clk, rst |=> !drive.valid)

endmodule

`default_nettype wire

/* hdl/lts_front.sv */
// front end: takes sensor beats and priority-encodes the highest lit sensor
`default_nettype none

module lts_front
  import lts_pkg::*;
#(
  parameter int SENSOR_COUNT = SENSOR_COUNT_DEF
) (
  lts_sense_if.sink sense,
  input  wire logic queue_full,
  output logic      push,
  output class_t    entry
);

  assign sense.ready = !queue_full;
  assign push        = sense.valid && !queue_full;

  // last hit wins, so the highest lit sensor sets the index
  always_comb begin
    entry.seen = 1'b0;
    entry.idx  = '0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      if (sense.sensor_bits[i]) begin
        entry.seen = 1'b1;
        entry.idx  = IDX_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/lts_queue.sv */
// small fifo between the front and back ends
`default_nettype none

module lts_queue
  import lts_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output logic                  not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/lts_back.sv */
// back end: error state, pid products, clamp and drive mix in three stages
`default_nettype none

module lts_back
  import lts_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire cfg_t   cfg,
  input  wire logic   q_valid,
  input  wire class_t q_entry,
  output logic        q_pop,
  lts_drive_if.source drive
);

  localparam int RAW_W  = IDX_W + 2;
  localparam int PP_W   = GAIN_W + 1 + ERR_W;
  localparam int PI_W   = GAIN_W + 1 + SUM_W;
  localparam int PD_W   = GAIN_W + 1 + DIFF_W;
  localparam int TERM_W = PI_W + 1;

  localparam logic signed [RAW_W-1:0] ERR_MAX = RAW_W'((1 << (ERR_W - 1)) - 1);
  localparam logic signed [RAW_W-1:0] ERR_MIN = -RAW_W'(1 << (ERR_W - 1));
  localparam logic signed [SUM_W:0]   SUM_MAX = (SUM_W + 1)'((1 << (SUM_W - 1)) - 1);
  localparam logic signed [SUM_W:0]   SUM_MIN = -(SUM_W + 1)'(1 << (SUM_W - 1));

  // state
  logic signed [ERR_W-1:0] prev_error;
  logic signed [SUM_W-1:0] error_sum;

  logic en;

  // stage 1
  logic                     v1;
  logic                     s1_seen;
  logic signed [ERR_W-1:0]  s1_err;
  logic signed [DIFF_W-1:0] s1_diff;
  logic signed [SUM_W-1:0]  s1_sum;

  // stage 2
  logic                   v2;
  logic                   s2_seen;
  logic signed [PP_W-1:0] s2_pp;
  logic signed [PI_W-1:0] s2_pi;
  logic signed [PD_W-1:0] s2_pd;

  // stage 3, output register
  logic                      v3;
  logic signed [DRIVE_W-1:0] s3_left;
  logic signed [DRIVE_W-1:0] s3_right;
  logic signed [STEER_W-1:0] s3_steer;
  logic                      s3_seen;

  logic signed [RAW_W-1:0]  raw_err;
  logic signed [ERR_W-1:0]  err_cur;
  logic signed [SUM_W:0]    sum_wide;
  logic signed [SUM_W-1:0]  sum_next;
  logic signed [DIFF_W-1:0] diff_cur;

  logic signed [TERM_W-1:0]  term;
  logic signed [TERM_W-1:0]  lim;
  logic signed [TERM_W-1:0]  clamped;
  logic signed [STEER_W-1:0] steer_next;

  assign en    = !v3 || drive.ready;
  assign q_pop = q_valid && en;

  always_comb begin
    raw_err = $signed({2'b00, q_entry.idx}) - $signed(RAW_W'(cfg.center_index));
    if (!q_entry.seen) begin
      err_cur = prev_error;
    end else if (raw_err > ERR_MAX) begin
      err_cur = ERR_W'(ERR_MAX);
    end else if (raw_err < ERR_MIN) begin
      err_cur = ERR_W'(ERR_MIN);
    end else begin
      err_cur = ERR_W'(raw_err);
    end
    diff_cur = DIFF_W'(err_cur) - DIFF_W'(prev_error);
    sum_wide = (SUM_W + 1)'(error_sum) + (SUM_W + 1)'(err_cur);
    if (sum_wide > SUM_MAX) begin
      sum_next = SUM_W'(SUM_MAX);
    end else if (sum_wide < SUM_MIN) begin
      sum_next = SUM_W'(SUM_MIN);
    end else begin
      sum_next = SUM_W'(sum_wide);
    end
  end

  always_comb begin
    term = TERM_W'(s2_pp) + TERM_W'(s2_pi) + TERM_W'(s2_pd);
    lim  = $signed(TERM_W'(cfg.steer_limit));
    if (term > lim) begin
      clamped = lim;
    end else if (term < -lim) begin
      clamped = -lim;
    end else begin
      clamped = term;
    end
    steer_next = STEER_W'(clamped);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_error <= '0;
      error_sum  <= '0;
      v1         <= 1'b0;
      v2         <= 1'b0;
      v3         <= 1'b0;
    end else begin
      if (q_pop) begin
        prev_error <= err_cur;
        error_sum  <= sum_next;
      end
      if (en) begin
        v1 <= q_valid;
        v2 <= v1;
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_seen  <= q_entry.seen;
      s1_err   <= err_cur;
      s1_diff  <= diff_cur;
      s1_sum   <= sum_next;
      s2_seen  <= s1_seen;
      s2_pp    <= PP_W'($signed({1'b0, cfg.gain_p})) * PP_W'(s1_err);
      s2_pi    <= PI_W'($signed({1'b0, cfg.gain_i})) * PI_W'(s1_sum);
      s2_pd    <= PD_W'($signed({1'b0, cfg.gain_d})) * PD_W'(s1_diff);
      s3_seen  <= s2_seen;
      s3_steer <= steer_next;
      s3_left  <= $signed(DRIVE_W'(cfg.base_speed)) + DRIVE_W'(steer_next);
      s3_right <= $signed(DRIVE_W'(cfg.base_speed)) - DRIVE_W'(steer_next);
    end
  end

  assign drive.valid        = v3;
  assign drive.left_drive   = s3_left;
  assign drive.right_drive  = s3_right;
  assign drive.steer_signal = s3_steer;
  assign drive.line_seen    = s3_seen;

endmodule

`default_nettype wire

/* tb/sv/line_tracking_pid_steer_chk.sv */
// scoreboard for the line tracking steering block: predicts drive beats and compares them
`timescale 1ns / 1ps

module line_tracking_pid_steer_chk
  import lts_pkg::*;
#(
  parameter int SENSOR_COUNT = SENSOR_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  input  logic                        sense_valid,
  input  logic                        sense_ready,
  input  logic [SENSOR_COUNT-1:0]     sensor_bits,
  input  logic                        drive_valid,
  input  logic                        drive_ready,
  input  logic signed [DRIVE_W-1:0]   left_drive,
  input  logic signed [DRIVE_W-1:0]   right_drive,
  input  logic signed [STEER_W-1:0]   steer_signal,
  input  logic                        line_seen,
  output int                          outstanding,
  output int                          failures
);

  typedef struct packed {
    logic signed [DRIVE_W-1:0] left;
    logic signed [DRIVE_W-1:0] right;
    logic signed [STEER_W-1:0] steer;
    logic                      seen;
  } wheel_cmd_t;

  cfg_t       regs;
  int         last_err;
  int         err_total;
  int         fails = 0;
  wheel_cmd_t wheel_cmds_due[$];

  function automatic int clip(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // one control tick: updates the tracked error and running sum
  function automatic wheel_cmd_t steer_for_sample(input logic [SENSOR_COUNT-1:0] bits);
    wheel_cmd_t cmd;
    int         err;
    int         diff;
    int         term;
    int         lim;
    int         steer;
    logic       hit;
    err = last_err;
    hit = 1'b0;
    // highest lit sensor wins
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      if (bits[i]) begin
        err = i - int'(regs.center_index);
        hit = 1'b1;
      end
    end
    err       = clip(err, -(1 << (ERR_W - 1)), (1 << (ERR_W - 1)) - 1);
    diff      = err - last_err;
    err_total = clip(err_total + err, -(1 << (SUM_W - 1)), (1 << (SUM_W - 1)) - 1);
    last_err  = err;
    term = int'(regs.gain_p) * err + int'(regs.gain_i) * err_total
         + int'(regs.gain_d) * diff;
    lim       = int'(regs.steer_limit);
    steer     = clip(term, -lim, lim);
    cmd.left  = DRIVE_W'(int'(regs.base_speed) + steer);
    cmd.right = DRIVE_W'(int'(regs.base_speed) - steer);
    cmd.steer = STEER_W'(steer);
    cmd.seen  = hit;
    return cmd;
  endfunction

  always @(posedge clk) begin
    wheel_cmd_t want;
    wheel_cmd_t got;
    if (rst) begin
      regs.gain_p       = GAIN_P_RST;
      regs.gain_i       = GAIN_I_RST;
      regs.gain_d       = GAIN_D_RST;
      regs.base_speed   = BASE_SPEED_RST;
      regs.steer_limit  = STEER_LIMIT_RST;
      regs.center_index = CENTER_RST;
      last_err          = 0;
      err_total         = 0;
      wheel_cmds_due.delete();
    end else begin
      if (drive_valid && drive_ready) begin
        got = '{left: left_drive, right: right_drive, steer: steer_signal, seen: line_seen};
        if (wheel_cmds_due.size() == 0) begin
          $error("drive beat with no sample outstanding");
          fails++;
        end else begin
          want = wheel_cmds_due.pop_front();
          if (got.left !== want.left) begin
            $error("left_drive: expected %0d, actual %0d", want.left, got.left);
            fails++;
          end
          if (got.right !== want.right) begin
            $error("right_drive: expected %0d, actual %0d", want.right, got.right);
            fails++;
          end
          if (got.steer !== want.steer) begin
            $error("steer_signal: expected %0d, actual %0d", want.steer, got.steer);
            fails++;
          end
          if (got.seen !== want.seen) begin
            $error("line_seen: expected %0b, actual %0b", want.seen, got.seen);
            fails++;
          end
        end
      end
      if (sense_valid && sense_ready) wheel_cmds_due.push_back(steer_for_sample(sensor_bits));
      if (cfg_we) begin
        case (cfg_index)
          REG_GAIN_P:      regs.gain_p       = cfg_data;
          REG_GAIN_I:      regs.gain_i       = cfg_data;
          REG_GAIN_D:      regs.gain_d       = cfg_data;
          REG_BASE_SPEED:  regs.base_speed   = cfg_data;
          REG_STEER_LIMIT: regs.steer_limit  = cfg_data;
          REG_CENTER:      regs.center_index = cfg_data[CENTER_W-1:0];
          default: ;
        endcase
      end
    end
    outstanding <= wheel_cmds_due.size();
    failures    <= fails;
  end

endmodule

/* tb/sv/line_tracking_pid_steer_tb.sv */
// top of the line tracking steering testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module line_tracking_pid_steer_tb;
  import lts_pkg::*;

  localparam int SENSOR_COUNT = SENSOR_COUNT_DEF;
  // cycles with no beat on either channel before the run is called hung
  localparam int STALL_LIMIT  = 2000;
  // register indexes past the last one, which the block must ignore
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
  // long one-sided runs that push the running sum far from zero
  localparam int SAT_UP_TICKS   = 250;
  localparam int SAT_DOWN_TICKS = 250;

  typedef logic [SENSOR_COUNT-1:0] sample_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    outstanding;
  int                    failures;
  int                    send_idle_pct  = 0;
  int                    recv_stall_pct = 0;
  int                    quiet_cycles   = 0;

  lts_sense_if #(.SENSOR_COUNT(SENSOR_COUNT)) sense_ch ();
  lts_drive_if                                drive_ch ();

  line_tracking_pid_steer #(
    .SENSOR_COUNT(SENSOR_COUNT)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .sense     (sense_ch),
    .drive     (drive_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // scoreboard sits beside the block and only watches
  line_tracking_pid_steer_chk #(
    .SENSOR_COUNT(SENSOR_COUNT)
  ) chk (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sense_valid  (sense_ch.valid),
    .sense_ready  (sense_ch.ready),
    .sensor_bits  (sense_ch.sensor_bits),
    .drive_valid  (drive_ch.valid),
    .drive_ready  (drive_ch.ready),
    .left_drive   (drive_ch.left_drive),
    .right_drive  (drive_ch.right_drive),
    .steer_signal (drive_ch.steer_signal),
    .line_seen    (drive_ch.line_seen),
    .outstanding  (outstanding),
    .failures     (failures)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // drive side back-pressure, re-rolled every cycle
  initial begin
    drive_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      drive_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // hang detector: any beat on either side restarts the count
  always @(posedge clk) begin
    if (rst || (sense_ch.valid && sense_ch.ready) || (drive_ch.valid && drive_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("line_tracking_pid_steer: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one sense beat, with random idle cycles ahead of it
  task automatic send_sample(input sample_t bits);
    while ($urandom_range(99) < send_idle_pct) begin
      sense_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sense_ch.valid       <= 1'b1;
    sense_ch.sensor_bits <= bits;
    @(posedge clk);
    while (!sense_ch.ready) @(posedge clk);
  endtask

  // hold the sense side until every predicted drive beat has been seen
  task automatic drain();
    sense_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // leaves the write enable high; the caller drops it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic load_config(input cfg_t c);
    write_reg(REG_GAIN_P, c.gain_p);
    write_reg(REG_GAIN_I, c.gain_i);
    write_reg(REG_GAIN_D, c.gain_d);
    write_reg(REG_BASE_SPEED, c.base_speed);
    write_reg(REG_STEER_LIMIT, c.steer_limit);
    // junk in the upper data bits, only the low three count
    write_reg(REG_CENTER, {(CFG_DATA_W - CENTER_W)'($urandom), c.center_index});
    cfg_we <= 1'b0;
  endtask

  // bytes lean towards the ends of the range
  function automatic logic [GAIN_W-1:0] pick_byte();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return GAIN_W'($urandom_range(15));
      default: return GAIN_W'($urandom_range(255));
    endcase
  endfunction

  function automatic cfg_t random_config();
    cfg_t c;
    c.gain_p       = pick_byte();
    c.gain_i       = pick_byte();
    c.gain_d       = pick_byte();
    c.base_speed   = pick_byte();
    c.steer_limit  = pick_byte();
    c.center_index = CENTER_W'($urandom_range(7));
    return c;
  endfunction

  // mostly a lit band under the line, some lost-line ticks and some noise
  function automatic sample_t pick_sample();
    int w;
    int pos;
    w   = $urandom_range(1, 3);
    pos = $urandom_range(0, SENSOR_COUNT - 1);
    case ($urandom_range(9))
      0, 1:          return '0;
      2, 3, 4, 5, 6: return sample_t'(((1 << w) - 1) << pos);
      default:       return sample_t'($urandom);
    endcase
  endfunction

  task automatic run_random(input int count);
    repeat (count) send_sample(pick_sample());
  endtask

  initial begin
    cfg_t c;
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_index            = '0;
    cfg_data             = '0;
    sense_ch.valid       = 1'b0;
    sense_ch.sensor_bits = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // first pass: sender idles a little, receiver stalls a lot
    send_idle_pct  = 10;
    recv_stall_pct = 76;

    // reset gains: lost line straight out of reset, then each sensor alone
    send_sample('0);
    for (int i = 0; i < SENSOR_COUNT; i++) send_sample(sample_t'(1) << i);
    send_sample('1);
    // line lost after the far edge: previous error carries on
    send_sample('0);
    drain();

    // everything at full scale, centre at the first sensor
    c = '{gain_p: '1, gain_i: '1, gain_d: '1, base_speed: '1, steer_limit: '1,
          center_index: '0};
    load_config(c);
    send_sample(sample_t'(1) << (SENSOR_COUNT - 1));
    send_sample('0);
    send_sample(sample_t'(1));
    drain();

    // writes past the last register must change nothing
    write_reg(REG_SPARE_6, CFG_DATA_W'($urandom));
    write_reg(REG_SPARE_7, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    send_sample('1);
    drain();

    // everything zero, zero steer limit forces a straight drive, centre past the array
    c = '{gain_p: '0, gain_i: '0, gain_d: '0, base_speed: '0, steer_limit: '0,
          center_index: '1};
    load_config(c);
    send_sample(sample_t'(1));
    send_sample('0);
    send_sample(sample_t'(1) << (SENSOR_COUNT - 1));
    drain();

    // hard swings with zero base speed, so the wheels go negative
    c = '{gain_p: '1, gain_i: '0, gain_d: '1, base_speed: '0, steer_limit: '1,
          center_index: '1};
    load_config(c);
    send_sample(sample_t'(1));
    send_sample(sample_t'(1) << (SENSOR_COUNT - 1));
    send_sample('0);
    send_sample(sample_t'(1) << 3);

    for (int seg = 0; seg < 6; seg++) begin
      drain();
      load_config(random_config());
      run_random(70);
    end

    // second pass: sender idles a lot, receiver rarely stalls
    send_idle_pct  = 76;
    recv_stall_pct = 10;
    for (int seg = 0; seg < 6; seg++) begin
      drain();
      load_config(random_config());
      run_random(70);
    end

    // third pass: neither side idles
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    // push the running sum well upwards: line at the far sensor or lost
    drain();
    c              = random_config();
    c.center_index = '0;
    load_config(c);
    repeat (SAT_UP_TICKS) begin
      if ($urandom_range(3) == 0) send_sample('0);
      else send_sample((sample_t'(1) << (SENSOR_COUNT - 1)) | sample_t'($urandom));
    end

    // and then well down again
    drain();
    c              = random_config();
    c.center_index = '1;
    load_config(c);
    repeat (SAT_DOWN_TICKS) begin
      if ($urandom_range(3) == 0) send_sample('0);
      else send_sample(sample_t'(1));
    end

    for (int seg = 0; seg < 5; seg++) begin
      drain();
      load_config(random_config());
      run_random(80);
    end

    // let the pipe empty, then a few spare cycles to catch stray beats
    drain();
    repeat (10) @(posedge clk);
    if (failures == 0) begin
      $display("line_tracking_pid_steer: match");
    end else begin
      $display("line_tracking_pid_steer: mismatch");
    end
    $finish;
  end

endmodule
